>>> rtl/core/itli_pkg.sv
package itli_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = 7;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [5:0]         entry_index;
		logic signed [31:0] lag_time;
		logic signed [31:0] aperture_in;
		logic signed [31:0] cutoff_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] aperture_out;
		logic signed [31:0] cutoff_out;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] lag;
		logic signed [31:0] aperture;
		logic signed [31:0] cutoff;
	} entry_t;

	// operands of one (dq * mag) / dx job
	typedef struct packed {
		logic [31:0] dq;
		logic [32:0] mag;
		logic [31:0] dx;
	} mdu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
	} mdu_rsp_t;

endpackage

>>> rtl/core/irregular_table_linear_interp.sv
// channel | direction | handshake             | payload
// in      | in        | in_valid / in_ready   | in_item  (in_item_t)
// out     | out       | out_valid / out_ready | out_item (out_item_t)
// cfg     | in        | cfg_we                | cfg_wdata (points_in_use)
//
// A write item is stored as it is accepted. A query reads the first and the last breakpoint,
// then a linear search reads the table entries in turn from the single read port, and the
// shared multiply/divide unit interpolates first the aperture, then the cutoff column.
// in_ready is high only while no query is in flight. A finished result waits in the
// output register; a second result waits in the sequencer until that register is free.
// Reset clears control state only; table contents are undefined until written.
module irregular_table_linear_interp
	import itli_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD0  = 8'b0000_0010,
		S_RDL  = 8'b0000_0100,
		S_CHK  = 8'b0000_1000,
		S_RDI  = 8'b0001_0000,
		S_CHKI = 8'b0010_0000,
		S_MDU  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   points_q;
	logic [ADDR_W-1:0]  last_q, idx_q, raddr, last_c;
	logic signed [31:0] q_q;
	entry_t             e0_q, prev_q, nxt_q, rdata;
	out_item_t          res_q, out_q;
	logic               out_valid_q, col_q, start_q;
	logic               accept, wr_en;
	mdu_req_t           req;
	mdu_rsp_t           rsp;
	logic signed [31:0] y1, y2, yres;
	logic signed [32:0] dy;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	// drop writes beyond the table
	assign wr_en = accept && (in_item.opcode == OP_WRITE)
		&& ({26'd0, in_item.entry_index} < 32'(TABLE_DEPTH));

	// last index in use: zero acts as one, oversize saturates to the table depth
	always_comb begin
		if (points_q == '0) begin
			last_c = '0;
		end else if ({25'd0, points_q} > 32'(TABLE_DEPTH)) begin
			last_c = ADDR_W'(TABLE_DEPTH - 1);
		end else begin
			last_c = ADDR_W'(points_q - 7'd1);
		end
	end

	always_comb begin
		unique case (state_q)
			S_RDL:   raddr = last_q;
			S_RDI:   raddr = idx_q;
			default: raddr = '0;
		endcase
	end

	itli_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ADDR_W'(in_item.entry_index)),
		.wdata ({in_item.lag_time, in_item.aperture_in, in_item.cutoff_in}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// interpolation operands for the current column
	always_comb begin
		y1 = col_q ? prev_q.cutoff : prev_q.aperture;
		y2 = col_q ? nxt_q.cutoff  : nxt_q.aperture;
		dy = {y2[31], y2} - {y1[31], y1};
		req.dq  = 32'(q_q - prev_q.lag);
		req.dx  = 32'(nxt_q.lag - prev_q.lag);
		req.mag = dy[32] ? 33'(-dy) : 33'(dy);
		yres = dy[32] ? 32'(y1 - $signed(rsp.quot)) : 32'(y1 + $signed(rsp.quot));
	end

	itli_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			points_q    <= CNT_W'(1);
			out_valid_q <= 1'b0;
			start_q     <= 1'b0;
			col_q       <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				points_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && in_item.opcode == OP_QUERY) begin
						state_q <= S_RD0;
					end
				end
				S_RD0: state_q <= S_RDL;
				S_RDL: state_q <= S_CHK;
				S_CHK: begin
					// clamp below the first and at or above the last breakpoint
					if (q_q < e0_q.lag || q_q >= rdata.lag) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_RDI;
					end
				end
				S_RDI: state_q <= S_CHKI;
				S_CHKI: begin
					if (rdata.lag > q_q || idx_q == last_q) begin
						state_q <= S_MDU;
						start_q <= 1'b1;
						col_q   <= 1'b0;
					end else begin
						state_q <= S_RDI;
					end
				end
				S_MDU: begin
					if (rsp.done) begin
						if (col_q) begin
							state_q <= S_OUT;
						end else begin
							col_q   <= 1'b1;
							start_q <= 1'b1;
						end
					end
				end
				S_OUT: begin
					// hold the result until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					q_q    <= in_item.lag_time;
					last_q <= last_c;
				end
			end
			S_RDL: e0_q <= rdata;
			S_CHK: begin
				if (q_q < e0_q.lag) begin
					res_q <= {e0_q.aperture, e0_q.cutoff};
				end else begin
					res_q <= {rdata.aperture, rdata.cutoff};
				end
				prev_q <= e0_q;
				idx_q  <= ADDR_W'(1);
			end
			S_CHKI: begin
				if (rdata.lag > q_q || idx_q == last_q) begin
					nxt_q <= rdata;
				end else begin
					prev_q <= rdata;
					idx_q  <= idx_q + ADDR_W'(1);
				end
			end
			S_MDU: begin
				if (rsp.done) begin
					if (col_q) begin
						res_q.cutoff_out <= yres;
					end else begin
						res_q.aperture_out <= yres;
					end
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> rtl/core/itli_ram.sv
module itli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/itli_mdu.sv
module itli_mdu
	import itli_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  mdu_req_t req,
	output mdu_rsp_t rsp
);

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_MUL  = 3'b010,
		U_DIV  = 3'b100
	} phase_t;

	phase_t      phase_q;
	logic [4:0]  cnt_q;
	logic [33:0] acc_q;
	logic [31:0] mlr_q;
	logic [32:0] mag_q;
	logic [31:0] dx_q;
	logic        done_q;

	logic [33:0] op_a, op_b, sum;
	logic        cin;

	// one adder: accumulate in the multiply phase, trial subtract in the divide phase
	always_comb begin
		if (phase_q == U_DIV) begin
			op_a = {acc_q[32:0], mlr_q[31]};
			op_b = ~{2'b00, dx_q};
			cin  = 1'b1;
		end else begin
			op_a = acc_q;
			op_b = mlr_q[0] ? {1'b0, mag_q} : 34'd0;
			cin  = 1'b0;
		end
		sum = op_a + op_b + {33'd0, cin};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= U_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				U_IDLE: begin
					if (start) begin
						phase_q <= U_MUL;
						cnt_q   <= '0;
					end
				end
				U_MUL: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						phase_q <= U_DIV;
					end
				end
				U_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						phase_q <= U_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			U_IDLE: begin
				if (start) begin
					acc_q <= '0;
					mlr_q <= req.dq;
					mag_q <= req.mag;
					dx_q  <= req.dx;
				end
			end
			U_MUL: begin
				acc_q <= {1'b0, sum[33:1]};
				mlr_q <= {sum[0], mlr_q[31:1]};
			end
			U_DIV: begin
				acc_q <= sum[33] ? op_a : sum;
				mlr_q <= {mlr_q[30:0], ~sum[33]};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quot = mlr_q;

endmodule
